### sv/cau_pkg.sv
// Shared types, constants and the saturating narrow function for the complex arithmetic unit.
// Used by cau_front, cau_queue, cau_div, cau_back and complex_arith_unit_core.
package cau_pkg;

    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 2 * DATA_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int DIV_ITER = DATA_W;
    localparam int DIV_LAT  = DIV_ITER + 2;
    localparam int REM_W    = PROD_W + DATA_W;

    typedef logic signed [DATA_W-1:0] data_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SAT      = 2'd1,
        STATUS_DIV_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        kind_t kind;
        logic  div_zero;
        data_t a_re;
        data_t a_im;
        data_t b_re;
        data_t b_im;
    } item_t;

    typedef struct packed {
        data_t val;
        logic  sat;
    } narrow_t;

    // Saturate a wide signed value to the data width.
    function automatic narrow_t narrow(input logic signed [SUM_W-1:0] v);
        narrow_t r;
        logic    fits;
        fits  = (&v[SUM_W-1:DATA_W-1]) | ~(|v[SUM_W-1:DATA_W-1]);
        r.sat = ~fits;
        r.val = fits ? v[DATA_W-1:0] : (v[SUM_W-1] ? DATA_MIN : DATA_MAX);
        return r;
    endfunction

endpackage

### sv/cau_front.sv
// Input stage: takes stream transactions, unpacks operands and flags zero divisors.
// Depends on cau_pkg.
module cau_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [127:0]          s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [1:0]            s_tuser,   // kind
    output logic                  out_valid,
    input  logic                  out_ready,
    output cau_pkg::item_t        out_item
);

    logic           vld_reg, vld_next;
    cau_pkg::item_t item_reg;
    cau_pkg::item_t item_next;

    assign s_tready = ~vld_reg | out_ready;

    always_comb begin
        item_next.kind     = cau_pkg::kind_t'(s_tuser);
        item_next.a_re     = s_tdata[31:0];
        item_next.a_im     = s_tdata[63:32];
        item_next.b_re     = s_tdata[95:64];
        item_next.b_im     = s_tdata[127:96];
        item_next.div_zero = (item_next.kind == cau_pkg::KIND_DIV)
                             && (item_next.b_re == '0) && (item_next.b_im == '0);
    end

    always_comb begin
        vld_next = vld_reg;
        if (s_tready) begin
            vld_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_item  = item_reg;

endmodule

### sv/cau_queue.sv
// Two-entry queue that decouples the input stage from the arithmetic pipeline.
// Depends on cau_pkg.
module cau_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cau_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output cau_pkg::item_t out_item
);

    cau_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### sv/cau_div.sv
// Pipelined restoring divider: signed numerator times 2^FRAC_W over a positive denominator,
// one quotient bit per stage, saturated to the data width. Depends on cau_pkg.
module cau_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [cau_pkg::SUM_W-1:0]  num,
    input  logic [cau_pkg::PROD_W-1:0]        den,
    output cau_pkg::data_t                    quo,
    output logic                              sat
);

    localparam int NI = cau_pkg::DIV_ITER;

    logic [cau_pkg::REM_W-1:0]  rem_reg [NI+1];
    logic [cau_pkg::PROD_W-1:0] den_reg [NI+1];
    logic [cau_pkg::DATA_W-1:0] q_reg   [NI+1];
    logic                       neg_reg [NI+1];
    logic                       ovf_reg [NI+1];

    logic [cau_pkg::SUM_W-1:0]  mag_full;
    logic [cau_pkg::PROD_W-1:0] mag;
    logic [cau_pkg::REM_W-1:0]  scaled;

    assign mag_full = num[cau_pkg::SUM_W-1] ? cau_pkg::SUM_W'(-num) : num;
    assign mag      = mag_full[cau_pkg::PROD_W-1:0];
    assign scaled   = {{(cau_pkg::DATA_W-cau_pkg::FRAC_W){1'b0}}, mag,
                       {cau_pkg::FRAC_W{1'b0}}};

    // The quotient exceeds the data width when the scaled numerator reaches den * 2^DATA_W.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= scaled;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[cau_pkg::SUM_W-1];
            ovf_reg[0] <= scaled >= {den, {cau_pkg::DATA_W{1'b0}}};
        end
    end

    for (genvar k = 0; k < NI; k++) begin : g_iter
        localparam int SH = NI - 1 - k;
        logic [cau_pkg::REM_W-1:0] dsh;
        logic                      ge;

        assign dsh = {{cau_pkg::DATA_W{1'b0}}, den_reg[k]} << SH;
        assign ge  = rem_reg[k] >= dsh;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? rem_reg[k] - dsh : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= q_reg[k] | (cau_pkg::DATA_W'(ge) << SH);
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    logic [cau_pkg::DATA_W-1:0] lim;
    logic                       sat_next;
    cau_pkg::data_t             quo_next;
    cau_pkg::data_t             quo_reg;
    logic                       sat_reg;

    always_comb begin
        lim      = neg_reg[NI] ? cau_pkg::DATA_MIN : cau_pkg::DATA_MAX;
        sat_next = ovf_reg[NI] || (q_reg[NI] > lim);
        if (sat_next) begin
            quo_next = neg_reg[NI] ? cau_pkg::DATA_MIN : cau_pkg::DATA_MAX;
        end else begin
            quo_next = neg_reg[NI] ? -q_reg[NI] : q_reg[NI];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

### sv/cau_back.sv
// Arithmetic pipeline: products, sums, saturation and the two dividers, then the output register.
// Depends on cau_pkg and cau_div.
module cau_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cau_pkg::item_t in_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata,   // res_re, res_im
    output logic [1:0]     m_tuser    // status
);

    localparam int LAT = cau_pkg::DIV_LAT;

    typedef struct packed {
        cau_pkg::kind_t kind;
        logic           div_zero;
        cau_pkg::data_t re;
        cau_pkg::data_t im;
        logic           sat;
    } side_t;

    logic en;
    assign en       = ~m_tvalid | m_tready;
    assign in_ready = en;

    // Stage 1: the six products and the add/subtract sums.
    logic                                 s1_vld_reg;
    cau_pkg::kind_t                       s1_kind_reg;
    logic                                 s1_dz_reg;
    logic signed [cau_pkg::PROD_W-1:0]    s1_rr_reg, s1_ii_reg, s1_ri_reg, s1_ir_reg;
    logic signed [cau_pkg::PROD_W-1:0]    s1_br2_reg, s1_bi2_reg;
    logic signed [cau_pkg::DATA_W:0]      s1_sre_reg, s1_sim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_kind_reg <= in_item.kind;
            s1_dz_reg   <= in_item.div_zero;
            s1_rr_reg   <= in_item.a_re * in_item.b_re;
            s1_ii_reg   <= in_item.a_im * in_item.b_im;
            s1_ri_reg   <= in_item.a_re * in_item.b_im;
            s1_ir_reg   <= in_item.a_im * in_item.b_re;
            s1_br2_reg  <= in_item.b_re * in_item.b_re;
            s1_bi2_reg  <= in_item.b_im * in_item.b_im;
            if (in_item.kind == cau_pkg::KIND_SUB) begin
                s1_sre_reg <= in_item.a_re - in_item.b_re;
                s1_sim_reg <= in_item.a_im - in_item.b_im;
            end else begin
                s1_sre_reg <= in_item.a_re + in_item.b_re;
                s1_sim_reg <= in_item.a_im + in_item.b_im;
            end
        end
    end

    // Stage 2: finish add, subtract and multiply; form the divide numerators and denominator.
    logic signed [cau_pkg::SUM_W-1:0] mre, mim, nre, nim;
    cau_pkg::narrow_t                 wre, wim;
    side_t                            side_next;
    logic [cau_pkg::PROD_W-1:0]       den_next;

    always_comb begin
        mre = (cau_pkg::SUM_W'(s1_rr_reg) - cau_pkg::SUM_W'(s1_ii_reg)) >>> cau_pkg::FRAC_W;
        mim = (cau_pkg::SUM_W'(s1_ri_reg) + cau_pkg::SUM_W'(s1_ir_reg)) >>> cau_pkg::FRAC_W;
        nre = cau_pkg::SUM_W'(s1_rr_reg) + cau_pkg::SUM_W'(s1_ii_reg);
        nim = cau_pkg::SUM_W'(s1_ir_reg) - cau_pkg::SUM_W'(s1_ri_reg);
        den_next = $unsigned(s1_br2_reg) + $unsigned(s1_bi2_reg);
        if (s1_kind_reg == cau_pkg::KIND_MUL) begin
            wre = cau_pkg::narrow(mre);
            wim = cau_pkg::narrow(mim);
        end else begin
            wre = cau_pkg::narrow(cau_pkg::SUM_W'(s1_sre_reg));
            wim = cau_pkg::narrow(cau_pkg::SUM_W'(s1_sim_reg));
        end
        side_next.kind     = s1_kind_reg;
        side_next.div_zero = s1_dz_reg;
        side_next.re       = wre.val;
        side_next.im       = wim.val;
        side_next.sat      = wre.sat | wim.sat;
    end

    logic                             vld_reg  [LAT+1];
    side_t                            side_reg [LAT+1];
    logic signed [cau_pkg::SUM_W-1:0] nre_reg, nim_reg;
    logic [cau_pkg::PROD_W-1:0]       den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            nre_reg     <= nre;
            nim_reg     <= nim;
            den_reg     <= den_next;
        end
    end

    // Delay line that keeps item data aligned with the divider stages.
    for (genvar k = 1; k <= LAT; k++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    cau_pkg::data_t qre, qim;
    logic           qre_sat, qim_sat;

    cau_div u_div_re (
        .aclk (aclk),
        .en   (en),
        .num  (nre_reg),
        .den  (den_reg),
        .quo  (qre),
        .sat  (qre_sat)
    );

    cau_div u_div_im (
        .aclk (aclk),
        .en   (en),
        .num  (nim_reg),
        .den  (den_reg),
        .quo  (qim),
        .sat  (qim_sat)
    );

    // Output register.
    side_t            last;
    cau_pkg::data_t   re_next, im_next;
    cau_pkg::status_t st_next;
    cau_pkg::data_t   re_reg, im_reg;
    cau_pkg::status_t st_reg;
    logic             out_vld_reg;

    assign last = side_reg[LAT];

    always_comb begin
        re_next = last.re;
        im_next = last.im;
        st_next = last.sat ? cau_pkg::STATUS_SAT : cau_pkg::STATUS_OK;
        if (last.kind == cau_pkg::KIND_DIV) begin
            if (last.div_zero) begin
                re_next = '0;
                im_next = '0;
                st_next = cau_pkg::STATUS_DIV_ZERO;
            end else begin
                re_next = qre;
                im_next = qim;
                st_next = (qre_sat | qim_sat) ? cau_pkg::STATUS_SAT : cau_pkg::STATUS_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[LAT];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {im_reg, re_reg};
    assign m_tuser  = st_reg;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && st_reg == cau_pkg::STATUS_DIV_ZERO) |-> (re_reg == '0 && im_reg == '0))
        else $error("divide-by-zero result has nonzero parts");

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && st_reg == cau_pkg::STATUS_SAT) |->
        (re_reg == cau_pkg::DATA_MAX || re_reg == cau_pkg::DATA_MIN
         || im_reg == cau_pkg::DATA_MAX || im_reg == cau_pkg::DATA_MIN))
        else $error("saturated status without a part at a bound");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(vld_reg[LAT]) && $stable(s1_vld_reg)))
        else $error("pipeline advanced during an output stall");
`endif

endmodule

### sv/complex_arith_unit_core.sv
// Complex add, subtract, multiply and divide on signed Q16.16 operands with saturation.
// Every item, whatever its kind, passes through the divider pipeline on its way to m_tvalid.
// Throughput: one transaction per cycle while m_tready does not stall the output.
// Reset: aresetn is synchronous and active low; it clears all valid bits and the queue.
// Depends on cau_pkg, cau_front, cau_queue, cau_back and cau_div.
module complex_arith_unit_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [1:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // res_re, res_im
    output logic [1:0]   m_tuser    // status
);

    logic           f_valid, f_ready;
    cau_pkg::item_t f_item;
    logic           q_valid, q_ready;
    cau_pkg::item_t q_item;

    cau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    cau_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    cau_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### test/cau_checker.sv
// Result checker for the complex arithmetic unit: predicts every result from the input stream.
// Depends on cau_pkg for the operation and status codes and the data type.
`timescale 1ns / 1ps

module cau_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [1:0]   s_tuser,   // kind
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,   // res_re, res_im
    input  logic [1:0]   m_tuser,   // status
    output int           errors,
    output int           pending
);

    typedef logic signed [127:0] wide_t;

    typedef struct {
        cau_pkg::data_t   re;
        cau_pkg::data_t   im;
        cau_pkg::status_t st;
    } cplx_res_t;

    cplx_res_t result_fifo[$];

    localparam wide_t TOP = 64'sh7FFF_FFFF;
    localparam wide_t BOT = -64'sh8000_0000;

    function automatic cau_pkg::data_t clamp(input wide_t v, inout bit sat);
        if (v > TOP) begin
            sat = 1'b1;
            return cau_pkg::data_t'(TOP);
        end else if (v < BOT) begin
            sat = 1'b1;
            return cau_pkg::data_t'(BOT);
        end
        return cau_pkg::data_t'(v);
    endfunction

    // Quotient num * 2^FRAC / den, truncated toward zero, den positive.
    function automatic cau_pkg::data_t quotient(input wide_t num, input wide_t den,
                                                inout bit sat);
        logic [127:0] mag;
        logic [127:0] q;
        bit           neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = (mag << cau_pkg::FRAC_W) / den;
        if (neg) return clamp(-wide_t'(q), sat);
        return clamp(wide_t'(q), sat);
    endfunction

    function automatic cplx_res_t predict(input cau_pkg::kind_t k,
                                          input cau_pkg::data_t a_re,
                                          input cau_pkg::data_t a_im,
                                          input cau_pkg::data_t b_re,
                                          input cau_pkg::data_t b_im);
        cplx_res_t r;
        wide_t     ar, ai, br, bi, den;
        bit        sat;
        ar  = a_re;
        ai  = a_im;
        br  = b_re;
        bi  = b_im;
        sat = 1'b0;
        case (k)
            cau_pkg::KIND_ADD: begin
                r.re = clamp(ar + br, sat);
                r.im = clamp(ai + bi, sat);
            end
            cau_pkg::KIND_SUB: begin
                r.re = clamp(ar - br, sat);
                r.im = clamp(ai - bi, sat);
            end
            cau_pkg::KIND_MUL: begin
                r.re = clamp((ar * br - ai * bi) >>> cau_pkg::FRAC_W, sat);
                r.im = clamp((ar * bi + ai * br) >>> cau_pkg::FRAC_W, sat);
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.st = cau_pkg::STATUS_DIV_ZERO;
                    return r;
                end
                r.re = quotient(ar * br + ai * bi, den, sat);
                r.im = quotient(ai * br - ar * bi, den, sat);
            end
        endcase
        r.st = sat ? cau_pkg::STATUS_SAT : cau_pkg::STATUS_OK;
        return r;
    endfunction

    always @(posedge aclk) begin
        cplx_res_t want;
        if (!aresetn) begin
            errors  <= 0;
            pending <= 0;
        end else begin
            if (s_tvalid && s_tready)
                result_fifo.push_back(predict(cau_pkg::kind_t'(s_tuser), s_tdata[31:0],
                                              s_tdata[63:32], s_tdata[95:64],
                                              s_tdata[127:96]));
            if (m_tvalid && m_tready) begin
                if (result_fifo.size() == 0) begin
                    if (errors < 10)
                        $display("ERROR: unexpected result re=%h im=%h status=%0d",
                                 m_tdata[31:0], m_tdata[63:32], m_tuser);
                    errors <= errors + 1;
                end else begin
                    want = result_fifo.pop_front();
                    if (m_tdata[31:0] !== want.re || m_tdata[63:32] !== want.im ||
                        m_tuser !== want.st) begin
                        if (errors < 10)
                            $display("ERROR: got re=%h im=%h status=%0d, want re=%h im=%h status=%0d",
                                     m_tdata[31:0], m_tdata[63:32], m_tuser,
                                     want.re, want.im, want.st);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= result_fifo.size();
        end
    end

endmodule

### test/tb_complex_arith_unit_core.sv
// Testbench top for complex_arith_unit_core: clock, reset, stimulus phases and verdict.
// Depends on cau_pkg, the block itself and cau_checker.
`timescale 1ns / 1ps

module tb_complex_arith_unit_core;

    localparam int STALL_LIMIT = 4000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = cau_pkg::KIND_ADD;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           errors;
    int           pending;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           quiet_cycles = 0;

    always #10 aclk = ~aclk;

    complex_arith_unit_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    cau_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(input cau_pkg::kind_t k, input cau_pkg::data_t ar,
                        input cau_pkg::data_t ai, input cau_pkg::data_t br,
                        input cau_pkg::data_t bi);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {bi, br, ai, ar};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Mostly small values so results stay in range, some full range and some extremes.
    function automatic cau_pkg::data_t pick_value();
        case ($urandom_range(9)) inside
            [0:2]:   return cau_pkg::data_t'($urandom);
            3:       return $urandom_range(1) ? cau_pkg::DATA_MAX : cau_pkg::DATA_MIN;
            4:       return cau_pkg::data_t'($signed($urandom_range(7)) - 3);
            default: return cau_pkg::data_t'($signed($urandom_range(32'h0040_0000))
                                             - 32'sh0020_0000);
        endcase
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int phase;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: saturation both ways, zero divisor, tiny divisor, rounding.
        send(cau_pkg::KIND_ADD, cau_pkg::DATA_MAX, cau_pkg::DATA_MIN, 32'sd1, -32'sd1);
        send(cau_pkg::KIND_ADD, cau_pkg::DATA_MIN, cau_pkg::DATA_MAX,
             cau_pkg::DATA_MIN, cau_pkg::DATA_MAX);
        send(cau_pkg::KIND_ADD, 32'sh0001_8000, -32'sh0002_0000, 32'sh0000_8000,
             32'sh0001_0000);
        send(cau_pkg::KIND_SUB, cau_pkg::DATA_MIN, cau_pkg::DATA_MAX, 32'sd1, -32'sd1);
        send(cau_pkg::KIND_SUB, cau_pkg::DATA_MAX, cau_pkg::DATA_MIN,
             cau_pkg::DATA_MIN, cau_pkg::DATA_MAX);
        send(cau_pkg::KIND_SUB, 32'sd0, 32'sd0, cau_pkg::DATA_MIN, cau_pkg::DATA_MIN);
        send(cau_pkg::KIND_MUL, cau_pkg::DATA_MIN, cau_pkg::DATA_MIN,
             cau_pkg::DATA_MIN, cau_pkg::DATA_MIN);
        send(cau_pkg::KIND_MUL, cau_pkg::DATA_MAX, cau_pkg::DATA_MIN,
             cau_pkg::DATA_MAX, cau_pkg::DATA_MAX);
        send(cau_pkg::KIND_MUL, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_8000,
             32'sh0000_4000);
        send(cau_pkg::KIND_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1);
        send(cau_pkg::KIND_MUL, 32'sd0, 32'sd0, cau_pkg::DATA_MAX, cau_pkg::DATA_MIN);
        send(cau_pkg::KIND_DIV, 32'sh0001_0000, 32'sh0002_0000, 32'sd0, 32'sd0);
        send(cau_pkg::KIND_DIV, cau_pkg::DATA_MIN, cau_pkg::DATA_MAX, 32'sd0, 32'sd0);
        send(cau_pkg::KIND_DIV, cau_pkg::DATA_MAX, cau_pkg::DATA_MIN, 32'sd1, 32'sd0);
        send(cau_pkg::KIND_DIV, 32'sh0001_0000, 32'sd0, 32'sd0, 32'sh0003_0000);
        send(cau_pkg::KIND_DIV, -32'sh0001_0000, 32'sh0000_0001, 32'sh0003_0000, 32'sd0);
        send(cau_pkg::KIND_DIV, cau_pkg::DATA_MIN, cau_pkg::DATA_MIN,
             cau_pkg::DATA_MIN, cau_pkg::DATA_MIN);
        send(cau_pkg::KIND_DIV, cau_pkg::DATA_MAX, cau_pkg::DATA_MAX,
             cau_pkg::DATA_MAX, cau_pkg::DATA_MIN);
        send(cau_pkg::KIND_DIV, 32'sd0, 32'sd0, -32'sd1, 32'sd1);
        send(cau_pkg::KIND_DIV, 32'sh0005_0000, -32'sh0002_0000, 32'sh0001_0000,
             32'sh0001_0000);
        drain();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            repeat (160) begin
                send(cau_pkg::kind_t'($urandom_range(3)), pick_value(), pick_value(),
                     pick_value(), pick_value());
            end
            if (phase == 1) drain();
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
sv/cau_pkg.sv
sv/cau_front.sv
sv/cau_queue.sv
sv/cau_div.sv
sv/cau_back.sv
sv/complex_arith_unit_core.sv
test/cau_checker.sv
test/tb_complex_arith_unit_core.sv
